>>> rtl/paired_fifo_matcher_with_cancel_defines.svh
// assertion macros for the paired fifo matcher
// used by the modules that carry concurrent assertions, no other dependencies
`ifndef PAIRED_FIFO_MATCHER_WITH_CANCEL_DEFINES_SVH
`define PAIRED_FIFO_MATCHER_WITH_CANCEL_DEFINES_SVH

// property that must hold at every edge outside reset
`define PFM_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication
`define PFM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pfm_pkg.sv
// shared types, constants and pointer helpers for the paired fifo matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int ID_WIDTH    = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int PTR_MOD     = 2 * QUEUE_DEPTH;
    localparam int PTR_W       = $clog2(PTR_MOD);
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [ID_WIDTH-1:0] id_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [ADDR_W-1:0]   addr_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_REQ = 2'd0,
        KIND_ADD_SRV = 2'd1,
        KIND_MATCH   = 2'd2,
        KIND_CANCEL  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_MATCH  = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REQ_RD,
        ST_REQ_CHK,
        ST_SRV_RD,
        ST_SRV_CHK,
        ST_CAN_RD,
        ST_CAN_CHK,
        ST_RESP
    } state_t;

    typedef struct packed {
        status_t status;
        id_t     server_id;
        id_t     requester_id;
    } result_t;

    // one write and one read request to a ring memory
    typedef struct packed {
        logic  we;
        addr_t waddr;
        id_t   wdata;
        addr_t raddr;
    } ram_req_t;

    // pointers count modulo twice the depth
    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic addr_t ptr_slot(input ptr_t p);
        return (p >= PTR_W'(QUEUE_DEPTH)) ? ADDR_W'(p - PTR_W'(QUEUE_DEPTH)) : ADDR_W'(p);
    endfunction

    function automatic ptr_t ring_count(input ptr_t head, input ptr_t tail);
        logic [PTR_W:0] diff;
        diff = {1'b0, tail} - {1'b0, head};
        if (tail < head) begin
            diff = diff + (PTR_W + 1)'(PTR_MOD);
        end
        return diff[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/paired_fifo_matcher_with_cancel.sv
// top level of the paired fifo matcher: two id rings, the sequencer and the result register
// depends on pfm_pkg, pfm_ram and pfm_ctrl
// input channel (s_valid/s_ready, s_kind, s_id) carries one command per transfer:
//   add requester, add server, match, or cancel requester by id
// result channel (m_valid/m_ready, m_status, m_server_id, m_requester_id) returns
//   exactly one result per command, in command order
// sequencing
//   one command is worked at a time; s_ready is high only while the sequencer is idle
//   add, or cancel of id zero: the result goes from the sequencer's result register into
//   the output register once that is free; the sequencer then returns to idle
//   match: a read state and a check state per requester slot and per server slot visited,
//   since each ring lookup waits for the registered read of its memory; tombstones at the
//   heads are popped on the way
//   cancel: read and check states per requester slot searched from the head, up to QUEUE_DEPTH
// reset
//   aresetn (synchronous, active low) empties both rings by zeroing the head and tail
//   pointers; no clearing pass is needed, memory contents outside the live range are unused
// stall
//   the output register holds a result while m_ready is low; the next command is
//   still taken and worked, and its result waits in the sequencer until the register frees up
`timescale 1ns / 1ps
`default_nettype none

module paired_fifo_matcher_with_cancel (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [pfm_pkg::KIND_W-1:0]       s_kind,
    input  wire logic [pfm_pkg::ID_WIDTH-1:0]     s_id,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [pfm_pkg::STATUS_W-1:0]          m_status,
    output logic [pfm_pkg::ID_WIDTH-1:0]          m_server_id,
    output logic [pfm_pkg::ID_WIDTH-1:0]          m_requester_id
);
    import pfm_pkg::*;

    ram_req_t req_ram;
    ram_req_t srv_ram;
    id_t      req_rdata;
    id_t      srv_rdata;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    // requester ring
    pfm_ram u_req_ram (
        .aclk  (aclk),
        .req   (req_ram),
        .rdata (req_rdata)
    );

    // server ring
    pfm_ram u_srv_ram (
        .aclk  (aclk),
        .req   (srv_ram),
        .rdata (srv_rdata)
    );

    pfm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_kind    (s_kind),
        .s_id      (s_id),
        .req_ram   (req_ram),
        .req_rdata (req_rdata),
        .srv_ram   (srv_ram),
        .srv_rdata (srv_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register: free when empty or when its result is transferred this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = STATUS_W'(m_res_reg.status);
    assign m_server_id    = m_res_reg.server_id;
    assign m_requester_id = m_res_reg.requester_id;

endmodule

`default_nettype wire

>>> rtl/pfm_ram.sv
// one ring of ids: single write port, single read port, registered read data
// depends on pfm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfm_ram (
    input  wire logic              aclk,
    input  wire pfm_pkg::ram_req_t req,
    output logic [pfm_pkg::ID_WIDTH-1:0] rdata
);
    import pfm_pkg::*;

    id_t mem [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pfm_ctrl.sv
// sequencer: pointers, tombstone skipping, cancel search and result build
// depends on pfm_pkg and the assertion macro header; drives two pfm_ram rings
`timescale 1ns / 1ps
`default_nettype none

`include "paired_fifo_matcher_with_cancel_defines.svh"

module pfm_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pfm_pkg::KIND_W-1:0]    s_kind,
    input  wire logic [pfm_pkg::ID_WIDTH-1:0]  s_id,
    output pfm_pkg::ram_req_t                  req_ram,
    input  wire logic [pfm_pkg::ID_WIDTH-1:0]  req_rdata,
    output pfm_pkg::ram_req_t                  srv_ram,
    input  wire logic [pfm_pkg::ID_WIDTH-1:0]  srv_rdata,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output pfm_pkg::result_t                   res
);
    import pfm_pkg::*;

    state_t  state_reg, state_next;
    ptr_t    rhead_reg, rhead_next;
    ptr_t    rtail_reg, rtail_next;
    ptr_t    shead_reg, shead_next;
    ptr_t    stail_reg, stail_next;
    ptr_t    walk_reg, walk_next;
    id_t     id_reg, id_next;
    id_t     match_req_reg, match_req_next;
    result_t res_reg, res_next;

    ptr_t  rcount;
    ptr_t  scount;
    kind_t kind_in;

    assign rcount  = ring_count(rhead_reg, rtail_reg);
    assign scount  = ring_count(shead_reg, stail_reg);
    assign kind_in = kind_t'(s_kind);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (kind_in)
                        KIND_MATCH:  state_next = ST_REQ_RD;
                        KIND_CANCEL: state_next = (s_id == '0) ? ST_RESP : ST_CAN_RD;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_REQ_RD:  state_next = (rhead_reg == rtail_reg) ? ST_RESP : ST_REQ_CHK;
            ST_REQ_CHK: state_next = (req_rdata == '0) ? ST_REQ_RD : ST_SRV_RD;
            ST_SRV_RD:  state_next = (shead_reg == stail_reg) ? ST_RESP : ST_SRV_CHK;
            ST_SRV_CHK: state_next = (srv_rdata == '0) ? ST_SRV_RD : ST_RESP;
            ST_CAN_RD:  state_next = (walk_reg == rtail_reg) ? ST_RESP : ST_CAN_CHK;
            ST_CAN_CHK: state_next = (req_rdata == id_reg) ? ST_RESP : ST_CAN_RD;
            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        res_valid      = (state_reg == ST_RESP);
        res            = res_reg;
        rhead_next     = rhead_reg;
        rtail_next     = rtail_reg;
        shead_next     = shead_reg;
        stail_next     = stail_reg;
        walk_next      = walk_reg;
        id_next        = id_reg;
        match_req_next = match_req_reg;
        res_next       = res_reg;

        req_ram.we     = 1'b0;
        req_ram.waddr  = ptr_slot(rtail_reg);
        req_ram.wdata  = s_id;
        req_ram.raddr  = (state_reg == ST_CAN_RD) ? ptr_slot(walk_reg) : ptr_slot(rhead_reg);
        srv_ram.we     = 1'b0;
        srv_ram.waddr  = ptr_slot(stail_reg);
        srv_ram.wdata  = s_id;
        srv_ram.raddr  = ptr_slot(shead_reg);

        case (state_reg)
            ST_IDLE: begin
                res_next.status       = STATUS_OK;
                res_next.server_id    = '0;
                res_next.requester_id = '0;
                id_next               = s_id;
                walk_next             = rhead_reg;
                if (s_valid) begin
                    case (kind_in)
                        KIND_ADD_REQ: begin
                            if (rcount == PTR_W'(QUEUE_DEPTH)) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                req_ram.we = 1'b1;
                                rtail_next = ptr_inc(rtail_reg);
                            end
                        end
                        KIND_ADD_SRV: begin
                            if (scount == PTR_W'(QUEUE_DEPTH)) begin
                                res_next.status = STATUS_FULL;
                            end else begin
                                srv_ram.we = 1'b1;
                                stail_next = ptr_inc(stail_reg);
                            end
                        end
                        KIND_CANCEL: begin
                            if (s_id == '0) begin
                                res_next.status = STATUS_NOT_FOUND;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_REQ_RD: begin
                if (rhead_reg == rtail_reg) begin
                    res_next.status = STATUS_NO_MATCH;
                end
            end
            ST_REQ_CHK: begin
                if (req_rdata == '0) begin
                    rhead_next = ptr_inc(rhead_reg);
                end else begin
                    match_req_next = req_rdata;
                end
            end
            ST_SRV_RD: begin
                if (shead_reg == stail_reg) begin
                    res_next.status = STATUS_NO_MATCH;
                end
            end
            ST_SRV_CHK: begin
                if (srv_rdata == '0) begin
                    shead_next = ptr_inc(shead_reg);
                end else begin
                    // pop both heads and leave tombstones behind
                    req_ram.we            = 1'b1;
                    req_ram.waddr         = ptr_slot(rhead_reg);
                    req_ram.wdata         = '0;
                    srv_ram.we            = 1'b1;
                    srv_ram.waddr         = ptr_slot(shead_reg);
                    srv_ram.wdata         = '0;
                    rhead_next            = ptr_inc(rhead_reg);
                    shead_next            = ptr_inc(shead_reg);
                    res_next.status       = STATUS_OK;
                    res_next.server_id    = srv_rdata;
                    res_next.requester_id = match_req_reg;
                end
            end
            ST_CAN_RD: begin
                if (walk_reg == rtail_reg) begin
                    res_next.status = STATUS_NOT_FOUND;
                end
            end
            ST_CAN_CHK: begin
                if (req_rdata == id_reg) begin
                    req_ram.we      = 1'b1;
                    req_ram.waddr   = ptr_slot(walk_reg);
                    req_ram.wdata   = '0;
                    res_next.status = STATUS_OK;
                end else begin
                    walk_next = ptr_inc(walk_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rhead_reg <= '0;
            rtail_reg <= '0;
            shead_reg <= '0;
            stail_reg <= '0;
        end else begin
            state_reg <= state_next;
            rhead_reg <= rhead_next;
            rtail_reg <= rtail_next;
            shead_reg <= shead_next;
            stail_reg <= stail_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg      <= walk_next;
        id_reg        <= id_next;
        match_req_reg <= match_req_next;
        res_reg       <= res_next;
    end

    `PFM_ASSERT_ALWAYS(a_req_occupancy, aclk, aresetn, rcount <= PTR_W'(QUEUE_DEPTH), "requester ring over depth")
    `PFM_ASSERT_ALWAYS(a_srv_occupancy, aclk, aresetn, scount <= PTR_W'(QUEUE_DEPTH), "server ring over depth")
    `PFM_ASSERT_NEXT(a_match_ids, aclk, aresetn, state_reg == ST_SRV_CHK && srv_rdata != '0, res_valid && res.server_id != '0 && res.requester_id != '0, "match without live ids")
    `PFM_ASSERT_NEXT(a_resp_release, aclk, aresetn, state_reg == ST_RESP && res_ready, state_reg == ST_IDLE, "result taken but sequencer not idle")

endmodule

`default_nettype wire
